FILE: src/msb_pkg.sv
// Shared types, constants and codes for the masked sprite blitter.
`timescale 1ns / 1ps

package msb_pkg;

    localparam int ROW_BYTES = 16;
    localparam int ROWS = 128;
    localparam int STORE_BYTES = ROW_BYTES * ROWS;
    localparam int STORE_AW = $clog2(STORE_BYTES);

    localparam int SPAN_MAX = 255 * ROW_BYTES + 32;
    localparam int LIN_MAX0 = (SPAN_MAX > 2048) ? SPAN_MAX : 2048;
    localparam int LIN_MAX = (LIN_MAX0 > STORE_BYTES) ? LIN_MAX0 : STORE_BYTES;
    localparam int LIN_W = $clog2(LIN_MAX);

    localparam int MAX_WIDTH = 16;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        FN_WRITE  = 2'd0,
        FN_READ   = 2'd1,
        FN_START  = 2'd2,
        FN_SPRITE = 2'd3
    } t_func;

    localparam logic [1:0] CFG_BLIT_X = 2'd0;
    localparam logic [1:0] CFG_BLIT_Y = 2'd1;
    localparam logic [1:0] CFG_WIDTH = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_START,
        ST_SPR_RD,
        ST_SPR_MRG,
        ST_PAD_MRG,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [6:0] blit_x;
        logic [6:0] blit_y;
        logic [4:0] width;
    } t_cfg;

endpackage

FILE: src/msb_if.sv
// Request, response and configuration channel interfaces of the blitter.
`timescale 1ns / 1ps

interface msb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [10:0] address;
    logic [7:0]  pixel_byte;
    logic [7:0]  mask_byte;

    modport source (output valid, func, address, pixel_byte, mask_byte, input ready);
    modport sink (input valid, func, address, pixel_byte, mask_byte, output ready);
endinterface

interface msb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       dropped;

    modport source (output valid, read_data, dropped, input ready);
    modport sink (input valid, read_data, dropped, output ready);
endinterface

interface msb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/msb_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module msb_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/msb_cfg.sv
// Configuration registers of the blitter with the sprite width clamped to its legal range.
`timescale 1ns / 1ps

module msb_cfg import msb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msb_cfg_if.sink       i_cfg,
    output t_cfg          o_cfg
);

    logic [6:0] r_blit_x;
    logic [6:0] r_blit_y;
    logic [4:0] r_width;
    logic       wr_en;

    assign i_cfg.ready = 1'b1;
    assign wr_en = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blit_x <= 7'd0;
            r_blit_y <= 7'd0;
            r_width <= 5'd1;
        end else if (wr_en) begin
            case (i_cfg.index)
                CFG_BLIT_X: r_blit_x <= i_cfg.data;
                CFG_BLIT_Y: r_blit_y <= i_cfg.data;
                CFG_WIDTH:  r_width <= i_cfg.data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.blit_x = r_blit_x;
        o_cfg.blit_y = r_blit_y;
        if (r_width == 5'd0) begin
            o_cfg.width = 5'd1;
        end else if (r_width > 5'(MAX_WIDTH)) begin
            o_cfg.width = 5'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_width;
        end
    end

endmodule

FILE: src/masked_sprite_blit.sv
// Top level of the masked sprite blitter: request sequencer, merge datapath and frame store.
// A write or a blit start passes through its own step, and a read through a read and a
// read-wait step; a sprite byte passes through a read and a merge step, plus a pad merge
// when it ends a row. Each result is then loaded into the output register.
// A new request is accepted only once the previous one has been loaded into the output
// register, set by the read-modify-write through the frame store's single read and write ports.
// Reset: synchronous and active low; afterwards a pass over all ROW_BYTES*ROWS (2048)
// addresses fills the frame store with 0xFF before the first request is accepted.
`timescale 1ns / 1ps

module masked_sprite_blit import msb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    msb_req_if.sink    i_req,
    msb_rsp_if.source  o_rsp,
    msb_cfg_if.sink    i_cfg
);

    t_cfg cfg;

    t_state r_state;
    t_state n_state;

    logic [1:0]          r_func;
    logic [10:0]         r_addr;
    logic [7:0]          r_pix;
    logic [7:0]          r_msk;
    logic [LIN_W-1:0]    r_lin;
    logic [LIN_W-1:0]    n_lin;
    logic [3:0]          r_col;
    logic [3:0]          n_col;
    logic [6:0]          r_row;
    logic [6:0]          n_row;
    logic [7:0]          r_cpix;
    logic [7:0]          n_cpix;
    logic [7:0]          r_cmsk;
    logic [7:0]          n_cmsk;
    logic [7:0]          r_pad_pix;
    logic [7:0]          n_pad_pix;
    logic [7:0]          r_pad_msk;
    logic [7:0]          n_pad_msk;
    logic [7:0]          r_res_rd;
    logic [7:0]          n_res_rd;
    logic                r_res_drop;
    logic                n_res_drop;
    logic [STORE_AW-1:0] r_clr;
    logic [STORE_AW-1:0] n_clr;
    logic                r_ov;
    logic                n_ov;
    logic [7:0]          r_o_rd;
    logic [7:0]          n_o_rd;
    logic                r_o_drop;
    logic                n_o_drop;

    logic                req_acc;
    logic                rsp_acc;
    logic                out_load;
    logic                clr_last;
    logic                mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic [7:0]          mem_wdata;
    logic [STORE_AW-1:0] mem_raddr;
    logic [7:0]          mem_rdata;

    logic [7:0]          ysum;
    logic [LIN_W-1:0]    row_base;
    logic [15:0]         pix_sh;
    logic [15:0]         msk_sh;
    logic [7:0]          spr_d;
    logic [7:0]          spr_m;
    logic                spr_last;
    logic                lin_ok;
    logic                addr_ok;
    logic [7:0]          mrg_d;
    logic [7:0]          mrg_m;
    logic [7:0]          merged;

    msb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    msb_ram #(
        .DEPTH (STORE_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ov;
    assign o_rsp.read_data = r_o_rd;
    assign o_rsp.dropped = r_o_drop;
    assign rsp_acc = r_ov && o_rsp.ready;
    assign out_load = (r_state == ST_DONE) && (!r_ov || o_rsp.ready);
    assign clr_last = (r_clr == STORE_AW'(STORE_BYTES - 1));

    // Sprite address and merge datapath.
    assign ysum = {1'b0, cfg.blit_y} + {1'b0, r_row};
    assign row_base = LIN_W'(ysum) * LIN_W'(ROW_BYTES) + LIN_W'(cfg.blit_x[6:3]);
    assign pix_sh = {r_pix, 8'h00} >> cfg.blit_x[2:0];
    assign msk_sh = {r_msk, 8'h00} >> cfg.blit_x[2:0];
    assign spr_d = pix_sh[15:8] | r_cpix;
    assign spr_m = msk_sh[15:8] | r_cmsk;
    assign spr_last = ({1'b0, r_col} + 5'd1) >= cfg.width;
    assign lin_ok = r_lin < LIN_W'(STORE_BYTES);
    assign addr_ok = LIN_W'(r_addr) < LIN_W'(STORE_BYTES);
    assign mrg_d = (r_state == ST_PAD_MRG) ? r_pad_pix : spr_d;
    assign mrg_m = (r_state == ST_PAD_MRG) ? r_pad_msk : spr_m;
    assign merged = (mem_rdata & ~mrg_m) | (mrg_d & mrg_m);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_acc) begin
                    case (t_func'(i_req.func))
                        FN_WRITE:  n_state = ST_WRITE;
                        FN_READ:   n_state = ST_READ;
                        FN_START:  n_state = ST_START;
                        FN_SPRITE: n_state = ST_SPR_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:     n_state = ST_DONE;
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: n_state = ST_DONE;
            ST_START:     n_state = ST_DONE;
            ST_SPR_RD:    n_state = ST_SPR_MRG;
            ST_SPR_MRG:   n_state = spr_last ? ST_PAD_MRG : ST_DONE;
            ST_PAD_MRG:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_lin = r_lin;
        n_col = r_col;
        n_row = r_row;
        n_cpix = r_cpix;
        n_cmsk = r_cmsk;
        n_pad_pix = r_pad_pix;
        n_pad_msk = r_pad_msk;
        n_res_rd = r_res_rd;
        n_res_drop = r_res_drop;
        n_clr = r_clr;
        mem_we = 1'b0;
        mem_waddr = r_lin[STORE_AW-1:0];
        mem_wdata = merged;
        mem_raddr = r_lin[STORE_AW-1:0];
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = FILL_BYTE;
                n_clr = r_clr + STORE_AW'(1);
            end
            ST_WRITE: begin
                mem_we = addr_ok;
                mem_waddr = r_addr[STORE_AW-1:0];
                mem_wdata = r_pix;
                n_res_rd = 8'h00;
                n_res_drop = !addr_ok;
            end
            ST_READ: begin
                mem_raddr = r_addr[STORE_AW-1:0];
            end
            ST_READ_WAIT: begin
                n_res_rd = addr_ok ? mem_rdata : 8'h00;
                n_res_drop = 1'b0;
            end
            ST_START: begin
                n_col = 4'd0;
                n_row = 7'd0;
                n_cpix = 8'h00;
                n_cmsk = 8'h00;
                n_res_rd = 8'h00;
                n_res_drop = 1'b0;
            end
            ST_SPR_RD: begin
                n_lin = row_base + LIN_W'(r_col);
                mem_raddr = n_lin[STORE_AW-1:0];
            end
            ST_SPR_MRG: begin
                mem_we = lin_ok;
                n_res_rd = 8'h00;
                n_res_drop = !lin_ok;
                if (spr_last) begin
                    n_lin = row_base + LIN_W'(cfg.width);
                    mem_raddr = n_lin[STORE_AW-1:0];
                    n_pad_pix = pix_sh[7:0];
                    n_pad_msk = msk_sh[7:0];
                    n_col = 4'd0;
                    n_row = r_row + 7'd1;
                    n_cpix = 8'h00;
                    n_cmsk = 8'h00;
                end else begin
                    n_col = r_col + 4'd1;
                    n_cpix = pix_sh[7:0];
                    n_cmsk = msk_sh[7:0];
                end
            end
            ST_PAD_MRG: begin
                mem_we = lin_ok;
                n_res_drop = r_res_drop || !lin_ok;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        n_o_rd = r_o_rd;
        n_o_drop = r_o_drop;
        if (out_load) begin
            n_ov = 1'b1;
            n_o_rd = r_res_rd;
            n_o_drop = r_res_drop;
        end else if (rsp_acc) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_col <= 4'd0;
            r_row <= 7'd0;
            r_cpix <= 8'h00;
            r_cmsk <= 8'h00;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_col <= n_col;
            r_row <= n_row;
            r_cpix <= n_cpix;
            r_cmsk <= n_cmsk;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_func <= i_req.func;
            r_addr <= i_req.address;
            r_pix <= i_req.pixel_byte;
            r_msk <= i_req.mask_byte;
        end
        r_lin <= n_lin;
        r_pad_pix <= n_pad_pix;
        r_pad_msk <= n_pad_msk;
        r_res_rd <= n_res_rd;
        r_res_drop <= n_res_drop;
        r_o_rd <= n_o_rd;
        r_o_drop <= n_o_drop;
    end

    // The sequencer leaves the idle state only in step with the latched function code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPR_RD) |-> (r_func == FN_SPRITE))
        else $error("Sprite sequence entered for a request that is not a sprite byte.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR || r_state == ST_WRITE ||
                    r_state == ST_SPR_MRG || r_state == ST_PAD_MRG))
        else $error("Frame store written outside a write or merge step.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPR_MRG && spr_last) |=> (r_state == ST_PAD_MRG && r_col == 4'd0))
        else $error("Row end did not proceed to the pad merge with the column cleared.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !out_load) |=> (r_state == ST_DONE && r_ov))
        else $error("Result left the sequencer while the output register was full.");

endmodule

FILE: tb/msb_checker.sv
// Checker for the masked sprite blitter: predicts every response and compares it.
`timescale 1ns / 1ps

module msb_checker import msb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    msb_req_if   i_req,
    msb_rsp_if   i_rsp,
    msb_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_outstanding
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       dropped;
    } t_blit_result;

    logic [7:0] frame_img [STORE_BYTES];
    logic [3:0] col_idx;
    logic [6:0] row_idx;
    logic [7:0] carry_pix;
    logic [7:0] carry_opq;
    logic [6:0] cfg_x;
    logic [6:0] cfg_y;
    logic [4:0] cfg_w;

    t_blit_result replies_due [$];
    int           mismatches;

    task automatic merge_frame(input int at, input logic [7:0] pix, input logic [7:0] opq,
                               output logic dropped);
        dropped = (at >= STORE_BYTES);
        if (!dropped) begin
            frame_img[at] = (frame_img[at] & ~opq) | (pix & opq);
        end
    endtask

    task automatic apply_request(input t_func fn, input logic [10:0] addr,
                                 input logic [7:0] pix, input logic [7:0] msk,
                                 output t_blit_result res);
        int          eff_w;
        int          row_base;
        int          sh;
        logic [15:0] pix_wide;
        logic [15:0] msk_wide;
        logic [7:0]  d;
        logic [7:0]  m;
        logic        body_drop;
        logic        pad_drop;
        res = '0;
        case (fn)
            FN_WRITE: begin
                if (int'(addr) < STORE_BYTES) begin
                    frame_img[addr] = pix;
                end else begin
                    res.dropped = 1'b1;
                end
            end
            FN_READ: begin
                if (int'(addr) < STORE_BYTES) begin
                    res.read_data = frame_img[addr];
                end
            end
            FN_START: begin
                col_idx = '0;
                row_idx = '0;
                carry_pix = '0;
                carry_opq = '0;
            end
            default: begin
                sh = int'(cfg_x[2:0]);
                if (cfg_w == 5'd0) begin
                    eff_w = 1;
                end else if (int'(cfg_w) > MAX_WIDTH) begin
                    eff_w = MAX_WIDTH;
                end else begin
                    eff_w = int'(cfg_w);
                end
                row_base = (int'(cfg_y) + int'(row_idx)) * ROW_BYTES + int'(cfg_x[6:3]);
                d = (pix >> sh) | carry_pix;
                m = (msk >> sh) | carry_opq;
                merge_frame(row_base + int'(col_idx), d, m, body_drop);
                pix_wide = {8'h00, pix} << (8 - sh);
                msk_wide = {8'h00, msk} << (8 - sh);
                carry_pix = pix_wide[7:0];
                carry_opq = msk_wide[7:0];
                res.dropped = body_drop;
                if (int'(col_idx) + 1 >= eff_w) begin
                    merge_frame(row_base + eff_w, carry_pix, carry_opq, pad_drop);
                    if (pad_drop) begin
                        res.dropped = 1'b1;
                    end
                    col_idx = '0;
                    row_idx = row_idx + 7'd1;
                    carry_pix = '0;
                    carry_opq = '0;
                end else begin
                    col_idx = col_idx + 4'd1;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_blit_result want;
        t_blit_result got;
        t_blit_result fresh;
        if (!i_rst_n) begin
            for (int a = 0; a < STORE_BYTES; a++) begin
                frame_img[a] = FILL_BYTE;
            end
            col_idx = '0;
            row_idx = '0;
            carry_pix = '0;
            carry_opq = '0;
            cfg_x = 7'd0;
            cfg_y = 7'd0;
            cfg_w = 5'd1;
            mismatches = 0;
            replies_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_BLIT_X: cfg_x = i_cfg.data;
                    CFG_BLIT_Y: cfg_y = i_cfg.data;
                    CFG_WIDTH:  cfg_w = i_cfg.data[4:0];
                    default: ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.read_data = i_rsp.read_data;
                got.dropped = i_rsp.dropped;
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("response with no request waiting: read_data %02h dropped %0d",
                                 got.read_data, got.dropped);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (got.read_data !== want.read_data || got.dropped !== want.dropped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected read_data %02h dropped %0d, got %02h %0d",
                                     want.read_data, want.dropped, got.read_data, got.dropped);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(t_func'(i_req.func), i_req.address, i_req.pixel_byte,
                              i_req.mask_byte, fresh);
                replies_due.push_back(fresh);
            end
        end
        o_outstanding <= replies_due.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the masked sprite blitter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import msb_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   burst_left;
    int   hold_asked = 0;
    logic [6:0] cur_x;
    logic [6:0] cur_y;

    msb_req_if req_ch ();
    msb_rsp_if rsp_ch ();
    msb_cfg_if cfg_ch ();

    masked_sprite_blit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    msb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : rsp_stall_gen
        int phase_left;
        int stall_pct;
        int holds_done;
        phase_left = 0;
        stall_pct = 0;
        holds_done = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked > holds_done) begin
                holds_done++;
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(10, 150);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                rsp_ch.ready <= (int'($urandom_range(0, 99)) >= stall_pct);
            end
        end
    end

    task automatic send_req(input t_func fn, input logic [10:0] addr, input logic [7:0] pix,
                            input logic [7:0] msk);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.func <= fn;
        req_ch.address <= addr;
        req_ch.pixel_byte <= pix;
        req_ch.mask_byte <= msk;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_blit(input logic [6:0] x, input logic [6:0] y, input logic [6:0] w,
                                input logic spare);
        write_reg(CFG_BLIT_X, x);
        write_reg(CFG_BLIT_Y, y);
        write_reg(CFG_WIDTH, w);
        if (spare) begin
            write_reg(CFG_SPARE, 7'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        cur_x = x;
        cur_y = y;
    endtask

    task automatic random_phase(input int n_items);
        int         sel;
        logic [10:0] near;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(0, 99);
            near = 11'((int'(cur_y) + int'($urandom_range(0, 6))) * ROW_BYTES
                       + int'(cur_x[6:3]) + int'($urandom_range(0, 17)));
            if (sel < 8) begin
                send_req(FN_START, 11'($urandom), 8'($urandom), 8'($urandom));
            end else if (sel < 65) begin
                send_req(FN_SPRITE, 11'($urandom), 8'($urandom), 8'($urandom));
            end else if (sel < 85) begin
                send_req(FN_READ, ($urandom_range(0, 1) == 1) ? near : 11'($urandom),
                         8'($urandom), 8'($urandom));
            end else begin
                send_req(FN_WRITE, ($urandom_range(0, 1) == 1) ? near : 11'($urandom),
                         8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [6:0] x;
        logic [6:0] y;
        logic [6:0] w;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FN_WRITE;
        req_ch.address <= '0;
        req_ch.pixel_byte <= '0;
        req_ch.mask_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_BLIT_X;
        cfg_ch.data <= '0;
        burst_left = 0;
        cur_x = 7'd0;
        cur_y = 7'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset, and sprite bytes sent without a blit start.
        send_req(FN_READ, 11'd0, 8'h00, 8'h00);
        send_req(FN_WRITE, 11'd0, 8'h00, 8'hFF);
        send_req(FN_READ, 11'd0, 8'hFF, 8'h00);
        send_req(FN_WRITE, 11'd2047, 8'hA5, 8'h5A);
        send_req(FN_READ, 11'd2047, 8'h00, 8'h00);
        send_req(FN_SPRITE, 11'd0, 8'hFF, 8'h0F);
        send_req(FN_READ, 11'd0, 8'h00, 8'h00);
        send_req(FN_READ, 11'd1, 8'h00, 8'h00);
        drain_results();

        // Far corner: the second byte and the pad fall off the end of the store.
        program_blit(7'd127, 7'd127, 7'd2, 1'b0);
        send_req(FN_START, 11'h7FF, 8'hFF, 8'hFF);
        send_req(FN_SPRITE, 11'd0, 8'h81, 8'hFF);
        send_req(FN_SPRITE, 11'd0, 8'h7E, 8'hFF);
        send_req(FN_SPRITE, 11'd0, 8'hFF, 8'h00);
        send_req(FN_READ, 11'd2047, 8'h00, 8'h00);
        drain_results();

        // A width of zero acts as one.
        program_blit(7'd13, 7'd3, 7'd0, 1'b0);
        send_req(FN_START, 11'd0, 8'h00, 8'h00);
        send_req(FN_SPRITE, 11'd0, 8'hC3, 8'hF0);
        send_req(FN_READ, 11'd49, 8'h00, 8'h00);
        send_req(FN_READ, 11'd50, 8'h00, 8'h00);
        drain_results();

        // A width above sixteen acts as sixteen.
        program_blit(7'd8, 7'd0, 7'd31, 1'b0);
        send_req(FN_START, 11'd0, 8'h00, 8'h00);
        send_req(FN_SPRITE, 11'd0, 8'hFF, 8'hFF);
        send_req(FN_SPRITE, 11'd0, 8'h00, 8'hFF);
        drain_results();

        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 4))
                0: x = 7'd0;
                1: x = 7'd127;
                default: x = 7'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: y = 7'd0;
                1: y = 7'd127;
                2: y = 7'($urandom);
                default: y = 7'($urandom_range(0, 30));
            endcase
            case ($urandom_range(0, 5))
                0: w = 7'd0;
                1: w = 7'd16;
                2: w = 7'($urandom_range(17, 127));
                default: w = 7'($urandom_range(1, 4));
            endcase
            if (ph == 5) begin
                w = 7'd1;
                y = 7'($urandom_range(0, 10));
            end
            program_blit(x, y, w, (ph == 0));
            if (ph == 2 || ph == 8) begin
                hold_asked <= hold_asked + 1;
            end
            if (ph == 5) begin
                // One byte per row for long enough that the row counter wraps twice.
                send_req(FN_START, 11'($urandom), 8'($urandom), 8'($urandom));
                for (int k = 0; k < 260; k++) begin
                    send_req(FN_SPRITE, 11'($urandom), 8'($urandom), 8'($urandom));
                end
            end else begin
                random_phase(75);
            end
            drain_results();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
